>>> src/tmr_pkg.sv
package tmr_pkg;

  localparam int TIMER_COUNT   = 4;
  localparam int FRACTION_BITS = 10;
  localparam int UNIT_BITS     = FRACTION_BITS + 1;
  localparam int COUNT_BITS    = 16;
  localparam int IRQ_BITS      = 4;
  localparam int STEP_BITS     = UNIT_BITS + 1;
  localparam int SUM_BITS      = COUNT_BITS + UNIT_BITS + 1;
  localparam int CTRL_BITS     = 5;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // control register layout
  localparam int CB_ENABLE  = 4;
  localparam int CB_IRQ     = 3;
  localparam int CB_CASCADE = 2;

  // control byte layout on the bus
  localparam int WD_ENABLE = 7;
  localparam int WD_IRQ    = 6;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_WR_RELOAD = 2'd1,
    OP_WR_CTRL   = 2'd2,
    OP_RD_COUNT  = 2'd3
  } tmr_op_t;

  typedef struct packed {
    tmr_op_t     operation;
    logic [1:0]  timer_index;
    logic [15:0] write_data;
  } tmr_in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [3:0]  irq_flags;
  } tmr_out_t;

  // broadcast to every channel
  typedef struct packed {
    logic                  tick;
    logic                  wr_reload;
    logic                  wr_ctrl;
    logic                  half_rate;
    logic [COUNT_BITS-1:0] data;
  } tmr_cmd_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  ovf;
    logic                  irq;
  } tmr_stat_t;

  // prescale code to step shift; log2 of ticks per count at full rate is 10 minus it
  function automatic logic [3:0] scale_shift(input logic [1:0] code);
    logic [3:0] s;
    unique case (code)
      2'd0:    s = 4'd10;
      2'd1:    s = 4'd4;
      2'd2:    s = 4'd2;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

>>> src/tmr_channel.sv
module tmr_channel (
  input  logic               clk,
  input  logic               rst_n,
  input  tmr_pkg::tmr_cmd_t  cmd,
  input  logic               sel,
  input  logic               casc_in,
  output tmr_pkg::tmr_stat_t stat
);
  import tmr_pkg::*;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [UNIT_BITS-1:0]  frac_r, frac_nxt;
  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  logic [CTRL_BITS-1:0]  ctrl_r, ctrl_nxt;

  logic                 en, irq_en, casc;
  logic [3:0]           shift;
  logic [STEP_BITS-1:0] step;
  logic [SUM_BITS-1:0]  sum;
  logic                 ticking, casc_hit, at_max, ovf;

  assign en     = ctrl_r[CB_ENABLE];
  assign irq_en = ctrl_r[CB_IRQ];
  assign casc   = ctrl_r[CB_CASCADE];
  assign shift  = scale_shift(ctrl_r[1:0]);

  // step in 1/2048 count units, halved at half rate
  assign step = (STEP_BITS'(1) << (shift + 4'd1)) >> cmd.half_rate;
  assign sum  = {1'b0, count_r, frac_r} + SUM_BITS'(step);

  assign ticking  = cmd.tick & en & ~casc;
  assign casc_hit = cmd.tick & en & casc & casc_in;
  assign at_max   = (count_r == COUNT_MAX);
  assign ovf      = (ticking & sum[SUM_BITS-1]) | (casc_hit & at_max);

  assign stat.count = count_r;
  assign stat.ovf   = ovf;
  assign stat.irq   = ovf & irq_en;

  always_comb begin
    count_nxt  = count_r;
    frac_nxt   = frac_r;
    reload_nxt = reload_r;
    ctrl_nxt   = ctrl_r;
    if (ticking) begin
      // on wrap the excess stays in the fraction
      frac_nxt  = sum[UNIT_BITS-1:0];
      count_nxt = sum[SUM_BITS-1] ? reload_r : sum[SUM_BITS-2:UNIT_BITS];
    end else if (casc_hit) begin
      if (at_max) begin
        count_nxt = reload_r;
        frac_nxt  = '0;
      end else begin
        count_nxt = count_r + COUNT_BITS'(1);
      end
    end
    if (sel && cmd.wr_reload) begin
      reload_nxt = cmd.data;
    end
    if (sel && cmd.wr_ctrl) begin
      if (!en && cmd.data[WD_ENABLE]) begin
        count_nxt = reload_r;
        frac_nxt  = '0;
      end
      ctrl_nxt = {cmd.data[WD_ENABLE], cmd.data[WD_IRQ], cmd.data[2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      frac_r   <= '0;
      reload_r <= '0;
      ctrl_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      frac_r   <= frac_nxt;
      reload_r <= reload_nxt;
      ctrl_r   <= ctrl_nxt;
    end
  end

endmodule

>>> src/four_channel_cascading_timer_core.sv
// Four 16-bit up-counting timers with prescaler and cascade.
// Input channel (in_valid/in_ready/in_data): one transaction is a tick,
// a reload write, a control write or a counter read for one timer.
// Result channel (out_valid/out_ready/out_data): exactly one result per
// input transaction, in order: the read count (zero unless a read) and
// the IRQ flags raised by this transaction's tick.
// cfg_write_en/cfg_write_data set the half-rate bit; write it only while
// the block holds no transaction.
// An accepted transaction is held in the input register, then processed
// into the output register, where out_valid rises and the result waits
// until out_ready takes it. Throughput is one transaction per cycle while
// out_ready stays high, set by the timer update including the cascade
// ripple across all four channels, which is combinational.
// When the receiver stalls, the result waits in the output register and
// the input register still takes one more transaction; in_ready then
// drops until out_ready returns.
// Reset (rst_n, synchronous) clears all counters, reloads and controls,
// so every timer starts disabled, and empties both registers.
module four_channel_cascading_timer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmr_pkg::tmr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tmr_pkg::tmr_out_t out_data,
  input  logic              cfg_write_en,
  input  logic              cfg_write_data
);
  import tmr_pkg::*;

  logic     in_valid_r;
  tmr_in_t  in_data_r;
  logic     out_valid_r;
  tmr_out_t out_data_r, out_data_nxt;
  logic     half_rate_r;
  logic     advance;

  tmr_cmd_t                     cmd;
  tmr_stat_t [TIMER_COUNT-1:0]  stat;
  logic      [TIMER_COUNT-1:0]  sel;
  logic      [TIMER_COUNT-1:0]  casc_in;

  assign advance  = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | advance;

  always_comb begin
    cmd.tick      = advance & (in_data_r.operation == OP_TICK);
    cmd.wr_reload = advance & (in_data_r.operation == OP_WR_RELOAD);
    cmd.wr_ctrl   = advance & (in_data_r.operation == OP_WR_CTRL);
    cmd.half_rate = half_rate_r;
    cmd.data      = in_data_r.write_data;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      sel[i] = (32'(in_data_r.timer_index) == i);
    end
  end

  // cascade ripple: each timer above timer 0 sees the overflow of the one below it
  assign casc_in[0] = 1'b0;
  for (genvar g = 1; g < TIMER_COUNT; g++) begin : g_chain
    assign casc_in[g] = stat[g-1].ovf;
  end

  for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_tmr
    tmr_channel u_channel (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .sel     (sel[g]),
      .casc_in (casc_in[g]),
      .stat    (stat[g])
    );
  end

  always_comb begin
    out_data_nxt = '0;
    if (in_data_r.operation == OP_RD_COUNT) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        if (sel[i]) begin
          out_data_nxt.read_value = stat[i].count;
        end
      end
    end
    // only the low four timers are visible in the flags
    for (int i = 0; i < TIMER_COUNT; i++) begin
      if (i < IRQ_BITS) begin
        out_data_nxt.irq_flags[i[1:0]] = stat[i].irq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      half_rate_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_write_en) begin
        half_rate_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
